// ----- hw/rtl/ids_pkg.sv -----
// Shared types and constants for the 2x2 box-filter image downscaler.
package ids_pkg;

  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned PSUM_W    = CHAN_W + 1;
  localparam int unsigned QSUM_W    = CHAN_W + 2;
  localparam int unsigned LINE_W    = 3 * PSUM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_DST_WIDTH  = 2'd2,
    CFG_DST_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [PSUM_W-1:0] red;
    logic [PSUM_W-1:0] green;
    logic [PSUM_W-1:0] blue;
  } psum_t;

  // Result waiting for the line store read data.
  typedef struct packed {
    logic  valid;
    logic  err;
    logic  done;
    psum_t pair;
  } stage_t;

endpackage

// ----- hw/rtl/image_downscale_by_half_core.sv -----
// Top level of the 2x2 box-filter image downscaler.
//
// Source RGB pixels enter in raster order on the in_ channel (valid/ready)
// and the block emits one output pixel per completed 2x2 block on the out_
// channel. Each output channel is the floor of the four-sample sum over four.
// The cfg_ port sets source and output sizes; write it only while idle.
// Throughput is one item per clock while the receiver does not stall. The line
// store takes one write or one read per accepted odd-column item inside the
// output window. The item that completes a block goes through the line store
// read into the read stage, then the final add into the output register.
// If the output size exceeds half the source size, no pixels come out and
// the last item of the frame yields one result with size_error and
// frame_done set. A zero output size yields nothing.
// Synchronous reset clears the position counters, the held pixel, the
// pipeline and restores the default sizes; the line store is not cleared
// since every entry is written on an even row before it is read.
// When the receiver stalls, the output register holds and the read stage
// behind it fills; in_ready drops only when both are occupied.
module image_downscale_by_half_core #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [ids_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ids_pkg::CFG_W-1:0]           cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ids_pkg::CHAN_W-1:0]          in_red,
  input  logic [ids_pkg::CHAN_W-1:0]          in_green,
  input  logic [ids_pkg::CHAN_W-1:0]          in_blue,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ids_pkg::CHAN_W-1:0]          out_red,
  output logic [ids_pkg::CHAN_W-1:0]          out_green,
  output logic [ids_pkg::CHAN_W-1:0]          out_blue,
  output logic                                out_frame_done,
  output logic                                out_size_error
);

  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned AW   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned WB   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HB   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DWW  = (WB > ids_pkg::CFG_W + 1) ? WB : ids_pkg::CFG_W + 1;
  localparam int unsigned DHW  = (HB > ids_pkg::CFG_W + 1) ? HB : ids_pkg::CFG_W + 1;

  // Configuration registers.
  logic [ids_pkg::CFG_W-1:0] src_width_r, src_height_r, dst_width_r, dst_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= ids_pkg::CFG_W'(2048);
      src_height_r <= ids_pkg::CFG_W'(2048);
      dst_width_r  <= ids_pkg::CFG_W'(1024);
      dst_height_r <= ids_pkg::CFG_W'(1024);
    end else if (cfg_wr_en) begin
      unique case (ids_pkg::cfg_idx_t'(cfg_index))
        ids_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_wr_data;
        ids_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_wr_data;
        ids_pkg::CFG_DST_WIDTH:  dst_width_r  <= cfg_wr_data;
        ids_pkg::CFG_DST_HEIGHT: dst_height_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Position and pipeline state.
  logic [CW-1:0]         col_r, col_nxt;
  logic [RW-1:0]         row_r, row_nxt;
  ids_pkg::rgb_t         held_r, held_nxt;
  ids_pkg::stage_t       s1_r, s1_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ids_pkg::rgb_t         out_pix_r, out_pix_nxt;
  logic                  out_done_r, out_done_nxt;
  logic                  out_err_r, out_err_nxt;

  logic [DWW-1:0]        w_lim, dst2_w, x_ext, src_w_ext;
  logic [DHW-1:0]        h_lim, dst2_h, y_ext, src_h_ext;
  logic                  bad, eor, eof, in_win, accept, s1_adv;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         line_idx;
  ids_pkg::psum_t        pair, line_rd;
  logic [ids_pkg::LINE_W-1:0] line_rd_raw;
  logic [ids_pkg::QSUM_W-1:0] q_red, q_green, q_blue;

  always_comb begin
    src_w_ext = DWW'(src_width_r);
    src_h_ext = DHW'(src_height_r);
    if (src_w_ext == '0)                 w_lim = DWW'(1);
    else if (src_w_ext > DWW'(MAX_WIDTH)) w_lim = DWW'(MAX_WIDTH);
    else                                 w_lim = src_w_ext;
    if (src_h_ext == '0)                  h_lim = DHW'(1);
    else if (src_h_ext > DHW'(MAX_HEIGHT)) h_lim = DHW'(MAX_HEIGHT);
    else                                  h_lim = src_h_ext;

    dst2_w = DWW'(dst_width_r) << 1;
    dst2_h = DHW'(dst_height_r) << 1;
    x_ext  = DWW'(col_r);
    y_ext  = DHW'(row_r);

    bad    = (dst2_w > w_lim) || (dst2_h > h_lim);
    eor    = x_ext >= (w_lim - DWW'(1));
    eof    = eor && (y_ext >= (h_lim - DHW'(1)));
    in_win = (x_ext < dst2_w) && (y_ext < dst2_h);

    s1_adv   = !out_valid_r || out_ready;
    in_ready = !s1_r.valid || s1_adv;
    accept   = in_valid && in_ready;

    pair.red   = ids_pkg::PSUM_W'(held_r.red)   + ids_pkg::PSUM_W'(in_red);
    pair.green = ids_pkg::PSUM_W'(held_r.green) + ids_pkg::PSUM_W'(in_green);
    pair.blue  = ids_pkg::PSUM_W'(held_r.blue)  + ids_pkg::PSUM_W'(in_blue);

    line_idx = AW'((col_r >> 1) & CW'(LINE_DEPTH - 1));
    // Even rows store pair sums, odd rows read them back, never both at once.
    ram_we = accept && !bad && in_win && col_r[0] && !row_r[0];
    ram_re = accept && !bad && in_win && col_r[0] && row_r[0];

    held_nxt = held_r;
    if (accept && !bad && in_win && !col_r[0]) begin
      held_nxt.red   = in_red;
      held_nxt.green = in_green;
      held_nxt.blue  = in_blue;
    end

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (eor) begin
        col_nxt = '0;
        row_nxt = eof ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end

    s1_nxt = s1_r;
    if (in_ready) begin
      s1_nxt.valid = accept && ((bad && eof) || ram_re);
      s1_nxt.err   = bad;
      s1_nxt.done  = bad || ((x_ext == dst2_w - DWW'(1)) && (y_ext == dst2_h - DHW'(1)));
      s1_nxt.pair  = pair;
    end

    line_rd = ids_pkg::psum_t'(line_rd_raw);
    q_red   = ids_pkg::QSUM_W'(s1_r.pair.red)   + ids_pkg::QSUM_W'(line_rd.red);
    q_green = ids_pkg::QSUM_W'(s1_r.pair.green) + ids_pkg::QSUM_W'(line_rd.green);
    q_blue  = ids_pkg::QSUM_W'(s1_r.pair.blue)  + ids_pkg::QSUM_W'(line_rd.blue);

    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    out_done_nxt  = out_done_r;
    out_err_nxt   = out_err_r;
    if (s1_adv) begin
      out_valid_nxt = s1_r.valid;
      out_done_nxt  = s1_r.done;
      out_err_nxt   = s1_r.err;
      if (s1_r.err) begin
        out_pix_nxt = '0;
      end else begin
        out_pix_nxt.red   = q_red[ids_pkg::QSUM_W-1:2];
        out_pix_nxt.green = q_green[ids_pkg::QSUM_W-1:2];
        out_pix_nxt.blue  = q_blue[ids_pkg::QSUM_W-1:2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      held_r      <= '0;
      s1_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      held_r      <= held_nxt;
      s1_r        <= s1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pix_r  <= out_pix_nxt;
    out_done_r <= out_done_nxt;
    out_err_r  <= out_err_nxt;
  end

  ids_ram #(
    .WIDTH (ids_pkg::LINE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (line_idx),
    .wr_data (pair),
    .rd_en   (ram_re),
    .rd_addr (line_idx),
    .rd_data (line_rd_raw)
  );

  assign out_valid      = out_valid_r;
  assign out_red        = out_pix_r.red;
  assign out_green      = out_pix_r.green;
  assign out_blue       = out_pix_r.blue;
  assign out_frame_done = out_done_r;
  assign out_size_error = out_err_r;

  // The line store is never written and read in the same cycle.
  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("line store written and read in one cycle");

  // An error result always closes the frame and carries a black pixel.
  a_err_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_size_error |-> out_frame_done &&
      out_red == '0 && out_green == '0 && out_blue == '0)
    else $error("size error result malformed");

  // A waiting read stage behind a stalled output keeps its item.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_r.valid && out_valid && !out_ready |=> s1_r.valid && $stable(line_rd_raw))
    else $error("read stage lost its item under stall");

  // Input is refused only when both stages are occupied.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_r.valid && out_valid && !out_ready)
    else $error("input stalled while pipeline had room");

endmodule

// ----- hw/rtl/ids_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module ids_ram #(
  parameter int unsigned WIDTH = 27,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
